// ----- design/wti_pkg.sv -----
// ----------------------------------------------------------------------------
// wti_pkg: shared types and constants for the wavetable interpolating reader
// Field widths, register indexes, command and mode codes, pipeline control.
// ----------------------------------------------------------------------------
package wti_pkg;

  // Parameter defaults
  localparam int unsigned DEF_TABLE_ADDR_BITS = 10;
  localparam int unsigned DEF_FRAC_BITS       = 16;
  localparam int unsigned DEF_SAMPLE_BITS     = 16;

  // Fixed field widths
  localparam int unsigned PHASE_BITS      = 32;
  localparam int unsigned ADDR_FIELD_BITS = 10;
  localparam int unsigned OFFSET_BITS     = 26;
  localparam int unsigned CFG_INDEX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS   = 26;
  localparam int unsigned NUM_BANKS       = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERP_MODE      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMALIZED_PHASE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_OFFSET     = 2'd2;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Interpolation modes; the unused code reads as cubic
  typedef enum logic [1:0] {
    MODE_TRUNC  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_CUBIC  = 2'd2
  } wti_mode_e;

  // Reset values of the configuration registers
  localparam wti_mode_e             RST_INTERP_MODE      = MODE_LINEAR;
  localparam logic                  RST_NORMALIZED_PHASE = 1'b1;
  localparam logic [OFFSET_BITS-1:0] RST_PHASE_OFFSET    = '0;

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic      valid;
    logic      lookup;
    logic      eob;
    wti_mode_e mode;
  } wti_ctl_t;

endpackage

// ----- design/wavetable_interp_lookup.sv -----
// ----------------------------------------------------------------------------
// wavetable_interp_lookup: wavetable reader with truncating, linear or cubic
// interpolation
// Banked sample table loaded by write items; lookups return one sample each.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                  Accepted when
//  s_axis    in         tdata phase/addr/data, tuser cmd, tlast   tvalid & tready
//  m_axis    out        tdata sample_out, tlast end_of_block_out  tvalid & tready
//  cfg       in         cfg_index_i, cfg_data_i                  cfg_valid_i & cfg_ready_o
//
//  One item per clock sustained while m_axis accepts results; a lookup result
//  is valid on m_axis once it has passed eight register stages (position,
//  table read, six interpolation stages).
//  Write items update the table in the read stage and produce no output.
//  Each stage holds its item until the next one frees; bubbles close up, so
//  input keeps flowing while the output register waits on m_axis_tready.
//  Reset clears control and configuration; table contents are not cleared.
// ----------------------------------------------------------------------------
module wavetable_interp_lookup import wti_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS,
  localparam int unsigned InDataW  =
    ((PHASE_BITS + ADDR_FIELD_BITS + SAMPLE_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [InDataW-1:0]        s_axis_tdata,  // phase, table_addr, table_data
  input  logic [0:0]                s_axis_tuser,  // command
  input  logic                      s_axis_tlast,
  // output stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OutDataW-1:0]       m_axis_tdata,  // sample_out
  output logic                      m_axis_tlast,
  // configuration writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  // Unpack input payload
  logic [PHASE_BITS-1:0]      phase;
  logic [ADDR_FIELD_BITS-1:0] table_addr;
  logic [SAMPLE_BITS-1:0]     table_data;

  assign phase      = s_axis_tdata[PHASE_BITS-1:0];
  assign table_addr = s_axis_tdata[PHASE_BITS +: ADDR_FIELD_BITS];
  assign table_data = s_axis_tdata[PHASE_BITS + ADDR_FIELD_BITS +: SAMPLE_BITS];

  // Stage 1: position
  wti_ctl_t                   ctl1, ctl2;
  logic [TABLE_ADDR_BITS-1:0] idx1, waddr1;
  logic [FRAC_BITS-1:0]       fr1, fr2;
  logic [SAMPLE_BITS-1:0]     wdata1;
  logic                       rdy2, rdy3;
  logic [1:0]                 base_lo2;
  logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] q2;
  logic [SAMPLE_BITS-1:0]     sample;

  wti_pos #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .command_i    (s_axis_tuser[0]),
    .phase_i      (phase),
    .table_addr_i (table_addr),
    .table_data_i (table_data),
    .eob_i        (s_axis_tlast),
    .nxt_ready_i  (rdy2),
    .ctl_o        (ctl1),
    .idx_o        (idx1),
    .fr_o         (fr1),
    .waddr_o      (waddr1),
    .wdata_o      (wdata1)
  );

  // Stage 2: banked table
  wti_table #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl1),
    .idx_i       (idx1),
    .fr_i        (fr1),
    .waddr_i     (waddr1),
    .wdata_i     (wdata1),
    .ready_o     (rdy2),
    .nxt_ready_i (rdy3),
    .ctl_o       (ctl2),
    .fr_o        (fr2),
    .base_lo_o   (base_lo2),
    .q_o         (q2)
  );

  // Stages 3-8: interpolation and output register
  wti_interp #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_interp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl2),
    .fr_i      (fr2),
    .base_lo_i (base_lo2),
    .q_i       (q2),
    .ready_o   (rdy3),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .sample_o  (sample),
    .eob_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OutDataW'(sample);

endmodule

// ----- design/wti_pos.sv -----
// ----------------------------------------------------------------------------
// wti_pos: configuration registers and position stage
// Holds the mode/phase registers and turns a lookup phase into a wrapped
// table index and fraction; registers write items for the table stage.
// ----------------------------------------------------------------------------
module wti_pos import wti_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data_i,
  // incoming item
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       command_i,
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  logic [ADDR_FIELD_BITS-1:0] table_addr_i,
  input  logic [SAMPLE_BITS-1:0]     table_data_i,
  input  logic                       eob_i,
  // stage 1 outputs
  input  logic                       nxt_ready_i,
  output wti_ctl_t                   ctl_o,
  output logic [TABLE_ADDR_BITS-1:0] idx_o,
  output logic [FRAC_BITS-1:0]       fr_o,
  output logic [TABLE_ADDR_BITS-1:0] waddr_o,
  output logic [SAMPLE_BITS-1:0]     wdata_o
);

  localparam int unsigned PosW = TABLE_ADDR_BITS + FRAC_BITS;

  wti_mode_e              mode_q;
  logic                   norm_q;
  logic [OFFSET_BITS-1:0] offset_q;

  wti_ctl_t                   ctl_q;
  logic [TABLE_ADDR_BITS-1:0] idx_q, waddr_q;
  logic [FRAC_BITS-1:0]       fr_q;
  logic [SAMPLE_BITS-1:0]     wdata_q;

  logic [PosW-1:0] norm_pos, raw_pos, pos;
  logic            load;

  // Config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= RST_INTERP_MODE;
      norm_q   <= RST_NORMALIZED_PHASE;
      offset_q <= RST_PHASE_OFFSET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INTERP_MODE:      mode_q   <= wti_mode_e'(cfg_data_i[1:0]);
        CFG_NORMALIZED_PHASE: norm_q   <= cfg_data_i[0];
        CFG_PHASE_OFFSET:     offset_q <= cfg_data_i[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position: scale cycle fraction to table positions when normalized, add offset, wrap
  assign norm_pos = PosW'({phase_i, {TABLE_ADDR_BITS{1'b0}}} >> (PHASE_BITS - FRAC_BITS));
  assign raw_pos  = PosW'(phase_i);
  assign pos      = (norm_q ? norm_pos : raw_pos) + PosW'(offset_q);

  // Stage 1 handshake
  assign load    = !ctl_q.valid || nxt_ready_i;
  assign ready_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (load) begin
      ctl_q.valid  <= valid_i;
      ctl_q.lookup <= (command_i == CMD_LOOKUP);
      ctl_q.eob    <= eob_i;
      ctl_q.mode   <= mode_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q   <= pos[PosW-1:FRAC_BITS];
      fr_q    <= pos[FRAC_BITS-1:0];
      waddr_q <= TABLE_ADDR_BITS'(table_addr_i);
      wdata_q <= table_data_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign idx_o   = idx_q;
  assign fr_o    = fr_q;
  assign waddr_o = waddr_q;
  assign wdata_o = wdata_q;

endmodule

// ----- design/wti_bank.sv -----
// ----------------------------------------------------------------------------
// wti_bank: one bank of the sample table
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module wti_bank import wti_pkg::*; #(
  parameter int unsigned ROW_BITS  = DEF_TABLE_ADDR_BITS - 2,
  parameter int unsigned WORD_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ROW_BITS-1:0]  waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ROW_BITS-1:0]  raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [2**ROW_BITS];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/wti_table.sv -----
// ----------------------------------------------------------------------------
// wti_table: four-bank sample table and read stage
// Entry j lives in bank j mod 4, so the four neighbors i-1..i+2 of a lookup
// fall into four different banks and are read together.
// ----------------------------------------------------------------------------
module wti_table import wti_pkg::*; #(
  parameter int unsigned TABLE_ADDR_BITS = DEF_TABLE_ADDR_BITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS,
  parameter int unsigned SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // from position stage
  input  wti_ctl_t                              ctl_i,
  input  logic [TABLE_ADDR_BITS-1:0]            idx_i,
  input  logic [FRAC_BITS-1:0]                  fr_i,
  input  logic [TABLE_ADDR_BITS-1:0]            waddr_i,
  input  logic [SAMPLE_BITS-1:0]                wdata_i,
  output logic                                  ready_o,
  // to interpolator
  input  logic                                  nxt_ready_i,
  output wti_ctl_t                              ctl_o,
  output logic [FRAC_BITS-1:0]                  fr_o,
  output logic [1:0]                            base_lo_o,
  output logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] q_o
);

  localparam int unsigned RowW = TABLE_ADDR_BITS - 2;

  wti_ctl_t                   ctl_q, ctl_d;
  logic [FRAC_BITS-1:0]       fr_q;
  logic [1:0]                 base_lo_q;
  logic [TABLE_ADDR_BITS-1:0] base;
  logic                       load, rd_en, wr_en;

  assign load    = !ctl_q.valid || nxt_ready_i;
  assign ready_o = load;
  assign rd_en   = load && ctl_i.valid && ctl_i.lookup;
  assign wr_en   = load && ctl_i.valid && !ctl_i.lookup;

  // First of the four neighbors, wrapping below zero
  assign base = idx_i - TABLE_ADDR_BITS'(1);

  // One bank per residue; each picks the neighbor that lands on it
  for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
    logic [1:0]                 off;
    logic [TABLE_ADDR_BITS-1:0] j;

    assign off = 2'(k) - base[1:0];
    assign j   = base + TABLE_ADDR_BITS'(off);

    wti_bank #(
      .ROW_BITS  (RowW),
      .WORD_BITS (SAMPLE_BITS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en && (waddr_i[1:0] == 2'(k))),
      .waddr_i (waddr_i[TABLE_ADDR_BITS-1:2]),
      .wdata_i (wdata_i),
      .re_i    (rd_en),
      .raddr_i (j[TABLE_ADDR_BITS-1:2]),
      .rdata_o (q_o[k])
    );
  end

  // Stage 2 control; write items end here
  always_comb begin
    ctl_d       = ctl_i;
    ctl_d.valid = ctl_i.valid && ctl_i.lookup;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (load) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      fr_q      <= fr_i;
      base_lo_q <= base[1:0];
    end
  end

  assign ctl_o     = ctl_q;
  assign fr_o      = fr_q;
  assign base_lo_o = base_lo_q;

endmodule

// ----- design/wti_interp.sv -----
// ----------------------------------------------------------------------------
// wti_interp: interpolation pipeline
// Six stages: coefficients, first products, two Horner steps, divide-by-6
// prep, then the reciprocal multiply, mode select and saturation.
// ----------------------------------------------------------------------------
module wti_interp import wti_pkg::*; #(
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wti_ctl_t                              ctl_i,
  input  logic [FRAC_BITS-1:0]                  fr_i,
  input  logic [1:0]                            base_lo_i,
  input  logic [NUM_BANKS-1:0][SAMPLE_BITS-1:0] q_i,
  output logic                                  ready_o,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [SAMPLE_BITS-1:0]                sample_o,
  output logic                                  eob_o
);

  localparam int unsigned SW   = SAMPLE_BITS;
  localparam int unsigned KW   = SW + 4;        // k2, k1
  localparam int unsigned K3W  = SW + 3;
  localparam int unsigned LDW  = SW + 1;        // linear difference
  localparam int unsigned FSW  = FRAC_BITS + 1; // fraction as signed
  localparam int unsigned M1W  = K3W + FSW;
  localparam int unsigned MLW  = LDW + FSW;
  localparam int unsigned S1W  = SW + 5;
  localparam int unsigned M2W  = S1W + FSW;
  localparam int unsigned S2W  = SW + 6;
  localparam int unsigned M3W  = S2W + FSW;
  localparam int unsigned NUMW = M3W + 1;
  localparam int unsigned HW   = NUMW - FRAC_BITS - 1;
  localparam int unsigned YW   = SW + 3;
  localparam int unsigned UW   = SW + 3;

  localparam logic signed [MLW-1:0]  LinRound = MLW'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [NUMW-1:0] CubRound = NUMW'(longint'(3) << FRAC_BITS);
  localparam logic signed [HW-1:0]   ClampHi  = HW'((longint'(3) << SW) - 1);
  localparam logic signed [HW-1:0]   ClampLo  = HW'(-(longint'(3) << SW));
  localparam logic signed [HW-1:0]   UOff     = HW'(longint'(3) << SW);
  localparam logic [UW-1:0]          Recip3   = UW'(((longint'(1) << (UW + 1)) + 2) / 3);
  localparam logic signed [YW-1:0]   QBias    = YW'(longint'(1) << SW);
  localparam logic signed [YW-1:0]   SatMax   = YW'((longint'(1) << (SW - 1)) - 1);
  localparam logic signed [YW-1:0]   SatMin   = YW'(-(longint'(1) << (SW - 1)));

  // Stage handshake chain
  wti_ctl_t ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctl7_q, ctl8_q;
  logic     en3, en4, en5, en6, en7, en8;

  assign en8     = !ctl8_q.valid || ready_i;
  assign en7     = !ctl7_q.valid || en8;
  assign en6     = !ctl6_q.valid || en7;
  assign en5     = !ctl5_q.valid || en6;
  assign en4     = !ctl4_q.valid || en5;
  assign en3     = !ctl3_q.valid || en4;
  assign ready_o = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
      ctl7_q <= '0;
      ctl8_q <= '0;
    end else begin
      if (en3) ctl3_q <= ctl_i;
      if (en4) ctl4_q <= ctl3_q;
      if (en5) ctl5_q <= ctl4_q;
      if (en6) ctl6_q <= ctl5_q;
      if (en7) ctl7_q <= ctl6_q;
      if (en8) ctl8_q <= ctl7_q;
    end
  end

  // Stage 3: line up neighbors, cubic coefficients, linear difference
  logic signed [SW-1:0]  a, b, c, d;
  logic signed [KW-1:0]  ax, bx, cx, dx, k3_full, k2_d, k1_d;
  logic signed [SW-1:0]  b3_q;
  logic signed [K3W-1:0] k3_q;
  logic signed [KW-1:0]  k2_3_q, k1_3_q;
  logic signed [LDW-1:0] ld_q;
  logic [FRAC_BITS-1:0]  fr3_q;

  always_comb begin
    case (base_lo_i)
      2'd0: begin
        a = signed'(q_i[0]); b = signed'(q_i[1]); c = signed'(q_i[2]); d = signed'(q_i[3]);
      end
      2'd1: begin
        a = signed'(q_i[1]); b = signed'(q_i[2]); c = signed'(q_i[3]); d = signed'(q_i[0]);
      end
      2'd2: begin
        a = signed'(q_i[2]); b = signed'(q_i[3]); c = signed'(q_i[0]); d = signed'(q_i[1]);
      end
      default: begin
        a = signed'(q_i[3]); b = signed'(q_i[0]); c = signed'(q_i[1]); d = signed'(q_i[2]);
      end
    endcase
  end

  assign ax = KW'(a);
  assign bx = KW'(b);
  assign cx = KW'(c);
  assign dx = KW'(d);
  // k3 = d - a + 3b - 3c ; k2 = 3a + 3c - 6b ; k1 = 6c - 2a - 3b - d
  assign k3_full = dx - ax + (bx <<< 1) + bx - (cx <<< 1) - cx;
  assign k2_d    = (ax <<< 1) + ax + (cx <<< 1) + cx - (bx <<< 2) - (bx <<< 1);
  assign k1_d    = (cx <<< 2) + (cx <<< 1) - (ax <<< 1) - (bx <<< 1) - bx - dx;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      b3_q   <= b;
      k3_q   <= K3W'(k3_full);
      k2_3_q <= k2_d;
      k1_3_q <= k1_d;
      ld_q   <= LDW'(c) - LDW'(b);
      fr3_q  <= fr_i;
    end
  end

  // Stage 4: k3 * fr and linear difference * fr
  logic signed [FSW-1:0] fr3_s;
  logic signed [M1W-1:0] m1_q;
  logic signed [MLW-1:0] ml_q;
  logic signed [KW-1:0]  k2_4_q, k1_4_q;
  logic signed [SW-1:0]  b4_q;
  logic [FRAC_BITS-1:0]  fr4_q;

  assign fr3_s = signed'({1'b0, fr3_q});

  always_ff @(posedge clk_i) begin
    if (en4) begin
      m1_q   <= M1W'(k3_q) * M1W'(fr3_s);
      ml_q   <= MLW'(ld_q) * MLW'(fr3_s);
      k2_4_q <= k2_3_q;
      k1_4_q <= k1_3_q;
      b4_q   <= b3_q;
      fr4_q  <= fr3_q;
    end
  end

  // Stage 5: s1 = floor(m1 / 2^F) + k2, then s1 * fr; finish linear result
  logic signed [FSW-1:0] fr4_s;
  logic signed [S1W-1:0] s1;
  logic signed [MLW-1:0] ml_rnd;
  logic signed [M2W-1:0] m2_q;
  logic signed [YW-1:0]  ylin5_q;
  logic signed [KW-1:0]  k1_5_q;
  logic signed [SW-1:0]  b5_q;
  logic [FRAC_BITS-1:0]  fr5_q;

  assign fr4_s  = signed'({1'b0, fr4_q});
  assign s1     = S1W'(m1_q >>> FRAC_BITS) + S1W'(k2_4_q);
  assign ml_rnd = ml_q + LinRound;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      m2_q    <= M2W'(s1) * M2W'(fr4_s);
      ylin5_q <= YW'(b4_q) + YW'(ml_rnd >>> FRAC_BITS);
      k1_5_q  <= k1_4_q;
      b5_q    <= b4_q;
      fr5_q   <= fr4_q;
    end
  end

  // Stage 6: s2 = floor(m2 / 2^F) + k1, then s2 * fr
  logic signed [FSW-1:0] fr5_s;
  logic signed [S2W-1:0] s2;
  logic signed [M3W-1:0] m3_q;
  logic signed [YW-1:0]  ylin6_q;
  logic signed [SW-1:0]  b6_q;

  assign fr5_s = signed'({1'b0, fr5_q});
  assign s2    = S2W'(m2_q >>> FRAC_BITS) + S2W'(k1_5_q);

  always_ff @(posedge clk_i) begin
    if (en6) begin
      m3_q    <= M3W'(s2) * M3W'(fr5_s);
      ylin6_q <= ylin5_q;
      b6_q    <= b5_q;
    end
  end

  // Stage 7: round, halve, clamp to a range that saturates alike, bias positive
  logic signed [NUMW-1:0] num;
  logic signed [HW-1:0]   h, hc;
  logic [UW-1:0]          u_q;
  logic signed [YW-1:0]   ylin7_q;
  logic signed [SW-1:0]   b7_q;

  assign num = NUMW'(m3_q) + CubRound;
  assign h   = HW'(num >>> (FRAC_BITS + 1));

  always_comb begin
    if (h > ClampHi) begin
      hc = ClampHi;
    end else if (h < ClampLo) begin
      hc = ClampLo;
    end else begin
      hc = h;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7) begin
      u_q     <= UW'(hc + UOff);
      ylin7_q <= ylin6_q;
      b7_q    <= b6_q;
    end
  end

  // Stage 8: floor(u / 3) by reciprocal, remove bias, select mode, saturate
  logic [2*UW-1:0]      prod;
  logic [UW-2:0]        q3u;
  logic signed [YW-1:0] ycub, ysel;
  logic [SW-1:0]        sample_q;

  assign prod = (2*UW)'(u_q) * (2*UW)'(Recip3);
  assign q3u  = prod[2*UW-1:UW+1];
  assign ycub = YW'(b7_q) + signed'({1'b0, q3u}) - QBias;

  always_comb begin
    case (ctl7_q.mode)
      MODE_TRUNC:  ysel = YW'(b7_q);
      MODE_LINEAR: ysel = ylin7_q;
      default:     ysel = ycub;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en8) begin
      if (ysel > SatMax) begin
        sample_q <= SatMax[SW-1:0];
      end else if (ysel < SatMin) begin
        sample_q <= SatMin[SW-1:0];
      end else begin
        sample_q <= ysel[SW-1:0];
      end
    end
  end

  assign valid_o  = ctl8_q.valid;
  assign eob_o    = ctl8_q.eob;
  assign sample_o = sample_q;

endmodule
